// ----- rtl/plhl_pkg.sv -----
package plhl_pkg;

	localparam int TABLE_ENTRIES_DEF = 4096;
	localparam int WAYS_DEF          = 4;

	// slot layout: valid, masked key, prefix length (0..32), value
	localparam int SLOT_W    = 103;
	localparam int SLOT_VLD  = 102;
	localparam int SLOT_KEY  = 38;
	localparam int SLOT_PLEN = 32;

	localparam int NUM_LENGTHS = 33;

	localparam logic [63:0] LEN_MULT   = 64'hC2B2_AE3D_27D4_EB4F;
	localparam logic [63:0] HASH_MULT  = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_ADD    = 2'd1,
		OP_DELETE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_FULL   = 2'd1,
		STAT_ABSENT = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SEL,
		ST_HASH,
		ST_READ,
		ST_CMP,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		HS_KEY  = 3'd0,
		HS_MLO  = 3'd1,
		HS_MHL  = 3'd2,
		HS_MLH  = 3'd3,
		HS_RCP  = 3'd4,
		HS_QB   = 3'd5,
		HS_FIX  = 3'd6
	} hstep_t;

endpackage

// ----- rtl/prefix_length_hash_lpm.sv -----
// Longest-prefix-match table over 64-bit keys {table_id, address}.
// Input channel (in_valid/in_stall) carries operation, table_id, address,
// prefix_length and entry_value; one transfer per item. Output channel
// (out_valid/out_stall) returns found_value, hit and status, one per item,
// in item order. Items are worked one at a time: in_stall stays high from
// the transfer until the result is moved into the output register.
// A hash probe runs the hash steps (key mask; three partial products, the
// reciprocal product and the quotient product on the shared 32x33
// multiplier, for the key hash and the bucket reduction; final correction),
// one bucket memory read and one compare and write-back; a lookup adds a
// selection step before each probe. A lookup makes at most 33 probes,
// longest present prefix length first; the unused operation goes
// straight to the result. The next transfer is taken in the idle state.
// After reset a clearing pass sweeps the bucket memory and the per-length
// counts, one row per cycle, over max(TABLE_ENTRIES/WAYS_PER_BUCKET, 33)
// rows (1024 at the defaults); no item is taken meanwhile.
// A finished result waits in the output register while out_stall is high;
// the next item may be taken meanwhile, but its result is held back until
// the register is free.
module prefix_length_hash_lpm #(
	parameter int TABLE_ENTRIES   = plhl_pkg::TABLE_ENTRIES_DEF,
	parameter int WAYS_PER_BUCKET = plhl_pkg::WAYS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [31:0] table_id,
	input  logic [31:0] address,
	input  logic [5:0]  prefix_length,
	input  logic [31:0] entry_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] found_value,
	output logic        hit,
	output logic [1:0]  status
);

	localparam int NB     = TABLE_ENTRIES / WAYS_PER_BUCKET;
	localparam int BW     = $clog2(NB);
	localparam int KSH    = $clog2(NB);
	localparam logic [32:0] RECIP = 33'((65'd1 << (32 + KSH)) / NB);
	localparam int ROW_W  = WAYS_PER_BUCKET * plhl_pkg::SLOT_W;
	localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
	localparam int CLR_N  = (NB > plhl_pkg::NUM_LENGTHS) ? NB : plhl_pkg::NUM_LENGTHS;
	localparam int CLR_W  = $clog2(CLR_N);
	localparam int WIW    = (WAYS_PER_BUCKET > 1) ? $clog2(WAYS_PER_BUCKET) : 1;

	plhl_pkg::state_t  state_q, state_d;
	plhl_pkg::hstep_t  step_q;
	plhl_pkg::op_t     op_q;
	plhl_pkg::status_t res_status_q;

	logic [CLR_W-1:0] clr_q;
	logic [63:0]      full_q, mkey_q, y_q;
	logic [5:0]       plen_q;
	logic [31:0]      val_q, h_q, q_q, r_q;
	logic [BW-1:0]    bkt_q;
	logic [32:0]      pres_q, pv_q;
	logic [31:0]      res_found_q;
	logic             res_hit_q;
	logic             ov_q;
	logic [31:0]      of_q;
	logic             oh_q;
	logic [1:0]       os_q;

	logic [ROW_W-1:0] bkt_mem [NB];
	logic [ROW_W-1:0] rd_row_q, wr_row;
	logic [CNT_W-1:0] cnt_mem [plhl_pkg::NUM_LENGTHS];
	logic [CNT_W-1:0] cnt_rd_q, cnt_wd;

	logic             mem_we, cnt_we, load_out, clr_last;
	logic [BW-1:0]    mem_wa;
	logic [5:0]       cnt_wa;

	// ---------------- probe selection ----------------
	logic [5:0] sel_idx;
	always_comb begin
		sel_idx = '0;
		for (int i = plhl_pkg::NUM_LENGTHS - 1; i >= 0; i--) begin
			if (pv_q[i]) sel_idx = 6'(i);
		end
	end

	// ---------------- key mask and hash ----------------
	logic [6:0]  len7;
	logic [63:0] mask, mkey, lc1;
	logic [31:0] mul_a;
	logic [32:0] mul_b;
	logic [64:0] prod;

	assign len7 = 7'(plen_q) + 7'd32;
	assign mask = ~(64'hFFFF_FFFF_FFFF_FFFF >> len7);
	assign mkey = full_q & mask;
	assign lc1  = {57'd0, len7} * plhl_pkg::LEN_MULT;

	always_comb begin
		case (step_q)
			plhl_pkg::HS_MLO: begin
				mul_a = y_q[31:0];
				mul_b = {1'b0, plhl_pkg::HASH_MULT[31:0]};
			end
			plhl_pkg::HS_MHL: begin
				mul_a = y_q[63:32];
				mul_b = {1'b0, plhl_pkg::HASH_MULT[31:0]};
			end
			plhl_pkg::HS_MLH: begin
				mul_a = y_q[31:0];
				mul_b = {1'b0, plhl_pkg::HASH_MULT[63:32]};
			end
			plhl_pkg::HS_RCP: begin
				mul_a = h_q;
				mul_b = RECIP;
			end
			plhl_pkg::HS_QB: begin
				mul_a = q_q;
				mul_b = 33'(NB);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = {33'd0, mul_a} * {32'd0, mul_b};

	// ---------------- bucket compare ----------------
	logic [WAYS_PER_BUCKET-1:0] way_match, way_free;
	logic                       match_any, free_any;
	logic [WIW-1:0]             match_idx, free_idx;

	always_comb begin
		for (int w = 0; w < WAYS_PER_BUCKET; w++) begin
			way_free[w]  = !rd_row_q[w*plhl_pkg::SLOT_W + plhl_pkg::SLOT_VLD];
			way_match[w] = rd_row_q[w*plhl_pkg::SLOT_W + plhl_pkg::SLOT_VLD]
				&& (rd_row_q[w*plhl_pkg::SLOT_W + plhl_pkg::SLOT_KEY +: 64] == mkey_q)
				&& (rd_row_q[w*plhl_pkg::SLOT_W + plhl_pkg::SLOT_PLEN +: 6] == plen_q);
		end
		match_idx = '0;
		free_idx  = '0;
		for (int w = WAYS_PER_BUCKET - 1; w >= 0; w--) begin
			if (way_match[w]) match_idx = WIW'(w);
			if (way_free[w])  free_idx  = WIW'(w);
		end
		match_any = |way_match;
		free_any  = |way_free;
	end

	logic [31:0] match_val;
	assign match_val = rd_row_q[int'(match_idx)*plhl_pkg::SLOT_W +: 32];

	always_comb begin
		wr_row = rd_row_q;
		if (state_q == plhl_pkg::ST_CLEAR) begin
			wr_row = '0;
		end else if (op_q == plhl_pkg::OP_ADD && match_any) begin
			wr_row[int'(match_idx)*plhl_pkg::SLOT_W +: 32] = val_q;
		end else if (op_q == plhl_pkg::OP_ADD && free_any) begin
			wr_row[int'(free_idx)*plhl_pkg::SLOT_W +: plhl_pkg::SLOT_W] =
				{1'b1, mkey_q, plen_q, val_q};
		end else if (op_q == plhl_pkg::OP_DELETE && match_any) begin
			wr_row[int'(match_idx)*plhl_pkg::SLOT_W + plhl_pkg::SLOT_VLD] = 1'b0;
		end
	end

	always_comb begin
		if (state_q == plhl_pkg::ST_CLEAR)
			cnt_wd = '0;
		else if (op_q == plhl_pkg::OP_ADD)
			cnt_wd = cnt_rd_q + CNT_W'(1);
		else if (cnt_rd_q != '0)
			cnt_wd = cnt_rd_q - CNT_W'(1);
		else
			cnt_wd = '0;
	end

	assign clr_last = (clr_q == CLR_W'(CLR_N - 1));

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			plhl_pkg::ST_CLEAR: if (clr_last) state_d = plhl_pkg::ST_IDLE;
			plhl_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (operation)
						plhl_pkg::OP_LOOKUP: state_d = plhl_pkg::ST_SEL;
						plhl_pkg::OP_ADD, plhl_pkg::OP_DELETE: state_d = plhl_pkg::ST_HASH;
						default: state_d = plhl_pkg::ST_DONE;
					endcase
				end
			end
			plhl_pkg::ST_SEL: state_d = (pv_q == '0) ? plhl_pkg::ST_DONE : plhl_pkg::ST_HASH;
			plhl_pkg::ST_HASH: if (step_q == plhl_pkg::HS_FIX) state_d = plhl_pkg::ST_READ;
			plhl_pkg::ST_READ: state_d = plhl_pkg::ST_CMP;
			plhl_pkg::ST_CMP: begin
				if (op_q == plhl_pkg::OP_LOOKUP && !match_any)
					state_d = plhl_pkg::ST_SEL;
				else
					state_d = plhl_pkg::ST_DONE;
			end
			plhl_pkg::ST_DONE: if (!ov_q || !out_stall) state_d = plhl_pkg::ST_IDLE;
			default: state_d = plhl_pkg::ST_CLEAR;
		endcase
	end

	// ---------------- control outputs ----------------
	always_comb begin
		in_stall = 1'b1;
		mem_we   = 1'b0;
		cnt_we   = 1'b0;
		load_out = 1'b0;
		mem_wa   = bkt_q;
		cnt_wa   = plen_q;
		case (state_q)
			plhl_pkg::ST_CLEAR: begin
				mem_we = (32'(clr_q) < 32'(NB));
				cnt_we = (32'(clr_q) < 32'(plhl_pkg::NUM_LENGTHS));
				mem_wa = clr_q[BW-1:0];
				cnt_wa = clr_q[5:0];
			end
			plhl_pkg::ST_IDLE: in_stall = 1'b0;
			plhl_pkg::ST_CMP: begin
				mem_we = (op_q == plhl_pkg::OP_ADD && (match_any || free_any))
					|| (op_q == plhl_pkg::OP_DELETE && match_any);
				cnt_we = (op_q == plhl_pkg::OP_ADD && !match_any && free_any)
					|| (op_q == plhl_pkg::OP_DELETE && match_any);
			end
			plhl_pkg::ST_DONE: load_out = !ov_q || !out_stall;
			default: ;
		endcase
	end

	// ---------------- memories ----------------
	always_ff @(posedge clk) begin
		if (mem_we) bkt_mem[mem_wa] <= wr_row;
		rd_row_q <= bkt_mem[bkt_q];
	end

	always_ff @(posedge clk) begin
		if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
		cnt_rd_q <= cnt_mem[plen_q];
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= plhl_pkg::ST_CLEAR;
			clr_q   <= '0;
			pres_q  <= '0;
			ov_q    <= 1'b0;
			step_q  <= plhl_pkg::HS_KEY;
		end else begin
			state_q <= state_d;
			if (state_q == plhl_pkg::ST_CLEAR) clr_q <= clr_q + CLR_W'(1);

			if (state_q == plhl_pkg::ST_HASH) begin
				step_q <= plhl_pkg::hstep_t'(step_q + 3'd1);
			end else begin
				step_q <= plhl_pkg::HS_KEY;
			end

			if (state_q == plhl_pkg::ST_CMP && cnt_we) begin
				// set on new entry, drop when the last entry of the length goes
				if (op_q == plhl_pkg::OP_ADD)
					pres_q[6'd32 - plen_q] <= 1'b1;
				else if (cnt_wd == '0)
					pres_q[6'd32 - plen_q] <= 1'b0;
			end

			if (load_out) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		case (state_q)
			plhl_pkg::ST_IDLE: begin
				if (in_valid) begin
					op_q         <= plhl_pkg::op_t'(operation);
					full_q       <= {table_id, address};
					plen_q       <= (prefix_length > 6'd32) ? 6'd32 : prefix_length;
					val_q        <= entry_value;
					pv_q         <= pres_q;
					res_found_q  <= plhl_pkg::MISS_VALUE;
					res_hit_q    <= 1'b0;
					res_status_q <= plhl_pkg::STAT_OK;
				end
			end
			plhl_pkg::ST_SEL: begin
				if (pv_q != '0) begin
					plen_q        <= 6'd32 - sel_idx;
					pv_q[sel_idx] <= 1'b0;
				end
			end
			plhl_pkg::ST_HASH: begin
				case (step_q)
					plhl_pkg::HS_KEY: begin
						mkey_q <= mkey;
						y_q    <= mkey ^ lc1;
					end
					plhl_pkg::HS_MLO: h_q <= prod[63:32];
					plhl_pkg::HS_MHL: h_q <= h_q + prod[31:0];
					plhl_pkg::HS_MLH: h_q <= h_q + prod[31:0];
					plhl_pkg::HS_RCP: q_q <= 32'(prod >> (32 + KSH));
					plhl_pkg::HS_QB:  r_q <= h_q - prod[31:0];
					plhl_pkg::HS_FIX: bkt_q <= BW'((r_q >= 32'(NB)) ? r_q - 32'(NB) : r_q);
					default: ;
				endcase
			end
			plhl_pkg::ST_CMP: begin
				case (op_q)
					plhl_pkg::OP_LOOKUP: begin
						if (match_any) begin
							res_found_q <= match_val;
							res_hit_q   <= 1'b1;
						end
					end
					plhl_pkg::OP_ADD: begin
						if (!match_any && !free_any) res_status_q <= plhl_pkg::STAT_FULL;
					end
					plhl_pkg::OP_DELETE: begin
						if (!match_any) res_status_q <= plhl_pkg::STAT_ABSENT;
					end
					default: ;
				endcase
			end
			default: ;
		endcase

		if (load_out) begin
			of_q <= res_found_q;
			oh_q <= res_hit_q;
			os_q <= res_status_q;
		end
	end

	assign out_valid   = ov_q;
	assign found_value = of_q;
	assign hit         = oh_q;
	assign status      = os_q;

	// ---------------- assertions ----------------
	a_cmp_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == plhl_pkg::ST_CMP |-> $past(state_q) == plhl_pkg::ST_READ)
		else $error("compare without memory read");

	a_clear_no_presence: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == plhl_pkg::ST_CLEAR |-> pres_q == '0)
		else $error("length present during clearing pass");

	a_hit_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> status == plhl_pkg::STAT_OK)
		else $error("hit reported with error status");

	a_load_free_reg: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !ov_q || !out_stall)
		else $error("result overwrote a held output");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;

	localparam int ENTRIES     = 4096;
	localparam int WAYS        = 4;
	localparam int BUCKETS     = ENTRIES / WAYS;
	localparam int IDLE_LIMIT  = 20000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  operation;
	logic [31:0] table_id;
	logic [31:0] address;
	logic [5:0]  prefix_length;
	logic [31:0] entry_value;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] found_value;
	logic        hit;
	logic [1:0]  status;

	typedef struct packed {
		logic [31:0] found_value;
		logic        hit;
		logic [1:0]  status;
	} answer_t;

	// shadow of the table
	logic [63:0] tbl_key [ENTRIES];
	logic [31:0] tbl_val [ENTRIES];
	logic [6:0]  tbl_len [ENTRIES];
	bit          tbl_used[ENTRIES];
	int unsigned len_count[plhl_pkg::NUM_LENGTHS];
	logic [32:0] len_mask;

	answer_t     pending_answers[$];
	int          error_count;
	int          idle_cycles;

	// key pool so that lookups and deletes hit stored prefixes
	logic [31:0] pool_tid[$];
	logic [31:0] pool_addr[$];
	logic [5:0]  pool_len[$];

	prefix_length_hash_lpm u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .table_id(table_id), .address(address),
		.prefix_length(prefix_length), .entry_value(entry_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.found_value(found_value), .hit(hit), .status(status)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [63:0] masked(logic [63:0] k, int unsigned l);
		if (l >= 64) return k;
		return k & ~(64'hFFFF_FFFF_FFFF_FFFF >> l);
	endfunction

	function automatic int unsigned bucket_base(logic [63:0] k, int unsigned l);
		logic [63:0] x;
		logic [63:0] lw;
		lw = 64'(l);
		x = (k ^ (lw * plhl_pkg::LEN_MULT)) * plhl_pkg::HASH_MULT;
		return 32'(((x >> 32) % 64'(BUCKETS)) * 64'(WAYS));
	endfunction

	function automatic int find_entry(logic [63:0] k, int unsigned l);
		int unsigned base;
		base = bucket_base(k, l);
		for (int w = 0; w < WAYS; w++)
			if (tbl_used[base + w] && tbl_key[base + w] == k && tbl_len[base + w] == l)
				return int'(base) + w;
		return -1;
	endfunction

	function automatic answer_t lpm_apply(plhl_pkg::op_t op, logic [31:0] tid,
			logic [31:0] addr, logic [5:0] plen_in, logic [31:0] v);
		answer_t a;
		logic [63:0] full;
		logic [63:0] k;
		int unsigned plen;
		int unsigned l;
		int s;
		int unsigned base;
		a.found_value = plhl_pkg::MISS_VALUE;
		a.hit = 1'b0;
		a.status = plhl_pkg::STAT_OK;
		full = {tid, addr};
		plen = (plen_in > 6'd32) ? 32 : 32'(plen_in);
		l = plen + 32;
		k = masked(full, l);
		case (op)
			plhl_pkg::OP_LOOKUP: begin
				for (int i = 0; i <= 32; i++) begin
					if (len_mask[i]) begin
						s = find_entry(masked(full, 64 - i), 64 - i);
						if (s >= 0) begin
							a.found_value = tbl_val[s];
							a.hit = 1'b1;
							break;
						end
					end
				end
			end
			plhl_pkg::OP_ADD: begin
				s = find_entry(k, l);
				if (s >= 0) begin
					tbl_val[s] = v;
				end else begin
					base = bucket_base(k, l);
					a.status = plhl_pkg::STAT_FULL;
					for (int w = 0; w < WAYS; w++) begin
						if (!tbl_used[base + w]) begin
							tbl_used[base + w] = 1'b1;
							tbl_key[base + w] = k;
							tbl_val[base + w] = v;
							tbl_len[base + w] = 7'(l);
							len_count[plen]++;
							len_mask[32 - plen] = 1'b1;
							a.status = plhl_pkg::STAT_OK;
							break;
						end
					end
				end
			end
			plhl_pkg::OP_DELETE: begin
				s = find_entry(k, l);
				if (s < 0) begin
					a.status = plhl_pkg::STAT_ABSENT;
				end else begin
					tbl_used[s] = 1'b0;
					if (len_count[plen] > 0) len_count[plen]--;
					if (len_count[plen] == 0) len_mask[32 - plen] = 1'b0;
				end
			end
			default: ;
		endcase
		return a;
	endfunction

	// drive one transfer; prediction is taken at acceptance
	task automatic send_item(plhl_pkg::op_t op, logic [31:0] tid, logic [31:0] addr,
			logic [5:0] plen, logic [31:0] v);
		in_valid <= 1'b1;
		operation <= op;
		table_id <= tid;
		address <= addr;
		prefix_length <= plen;
		entry_value <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_answers.push_back(lpm_apply(op, tid, addr, plen, v));
		if (op == plhl_pkg::OP_ADD) begin
			pool_tid.push_back(tid);
			pool_addr.push_back(addr);
			pool_len.push_back(plen);
		end
		// burst gaps
		if ($urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic test_directed();
		send_item(plhl_pkg::OP_LOOKUP, 32'h0, 32'h0, 6'd0, 32'h0);
		send_item(plhl_pkg::OP_DELETE, 32'h1, 32'h0A00_0000, 6'd8, 32'h0);
		send_item(plhl_pkg::OP_ADD, 32'h1, 32'h0A00_0000, 6'd8, 32'h1111);
		send_item(plhl_pkg::OP_ADD, 32'h1, 32'h0A01_0000, 6'd16, 32'h2222);
		send_item(plhl_pkg::OP_ADD, 32'h1, 32'h0A01_0203, 6'd32, 32'h3333);
		send_item(plhl_pkg::OP_LOOKUP, 32'h1, 32'h0A01_0203, 6'd0, 32'h0);
		send_item(plhl_pkg::OP_LOOKUP, 32'h1, 32'h0A01_0204, 6'd0, 32'h0);
		send_item(plhl_pkg::OP_LOOKUP, 32'h1, 32'h0AFF_0000, 6'd0, 32'h0);
		send_item(plhl_pkg::OP_LOOKUP, 32'h2, 32'h0A01_0203, 6'd0, 32'h0);
		// re-add overwrites
		send_item(plhl_pkg::OP_ADD, 32'h1, 32'h0A00_0000, 6'd8, 32'hFFFF_FFFE);
		send_item(plhl_pkg::OP_LOOKUP, 32'h1, 32'h0A99_0000, 6'd0, 32'h0);
		// long prefix saturates; same key at another length
		send_item(plhl_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 32'h0);
		send_item(plhl_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0, 32'h55);
		send_item(plhl_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0, 32'h0);
		send_item(plhl_pkg::OP_DELETE, 32'hFFFF_FFFF, 32'h0, 6'd33, 32'h0);
		send_item(plhl_pkg::OP_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd32, 32'h0);
		send_item(plhl_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0, 32'h0);
		send_item(plhl_pkg::OP_NONE, 32'h1, 32'h0A01_0203, 6'd32, 32'h7);
		send_item(plhl_pkg::OP_DELETE, 32'h1, 32'h0A01_0000, 6'd16, 32'h0);
		send_item(plhl_pkg::OP_LOOKUP, 32'h1, 32'h0A01_0203, 6'd0, 32'h0);
	endtask

	// fill one bucket past its ways: /32 host prefixes that share a bucket
	task automatic test_full_bucket();
		logic [63:0] k0;
		int unsigned b0;
		int found;
		logic [31:0] a;
		k0 = {32'h7, 32'h0};
		b0 = bucket_base(k0, 64);
		found = 0;
		a = 0;
		while (found < WAYS + 2) begin
			if (bucket_base({32'h7, a}, 64) == b0) begin
				send_item(plhl_pkg::OP_ADD, 32'h7, a, 6'd32, a);
				found++;
			end
			a++;
		end
		send_item(plhl_pkg::OP_LOOKUP, 32'h7, 32'h0, 6'd0, 32'h0);
	endtask

	task automatic test_random(int count);
		int idx;
		int sel;
		logic [31:0] tid;
		logic [31:0] addr;
		logic [5:0] plen;
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(0, 99);
			if (pool_tid.size() > 0 && sel < 75) begin
				idx = $urandom_range(0, pool_tid.size() - 1);
				tid = pool_tid[idx];
				addr = pool_addr[idx] ^ ($urandom_range(0, 1) ? 32'h0 : ($urandom >> pool_len[idx]));
				plen = pool_len[idx];
			end else begin
				tid = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3);
				addr = $urandom;
				plen = 6'($urandom_range(0, 63));
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3: send_item(plhl_pkg::OP_LOOKUP, tid, addr, 6'($urandom), $urandom);
				4, 5, 6:    send_item(plhl_pkg::OP_ADD, tid, addr, plen, $urandom);
				7, 8:       send_item(plhl_pkg::OP_DELETE, tid, addr, plen, $urandom);
				default:    send_item(plhl_pkg::OP_NONE, tid, addr, plen, $urandom);
			endcase
		end
	endtask

	// receiver: own stall pattern, with quiet stretches
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if ($urandom_range(0, 199) < 20) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 2) == 0);
		end
	end

	always @(posedge clk) begin
		answer_t exp_a;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_answers.size() == 0) begin
				$error("result with nothing expected: found_value %h", found_value);
				error_count++;
			end else begin
				exp_a = pending_answers.pop_front();
				if (found_value !== exp_a.found_value) begin
					$error("found_value expected %h actual %h", exp_a.found_value, found_value);
					error_count++;
				end
				if (hit !== exp_a.hit) begin
					$error("hit expected %0d actual %0d", exp_a.hit, hit);
					error_count++;
				end
				if (status !== exp_a.status) begin
					$error("status expected %0d actual %0d", exp_a.status, status);
					error_count++;
				end
			end
		end
	end

	// watchdog: cycles with no transfer on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("prefix_length_hash_lpm verification failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = plhl_pkg::OP_LOOKUP;
		table_id = '0;
		address = '0;
		prefix_length = '0;
		entry_value = '0;
		error_count = 0;
		idle_cycles = 0;
		len_mask = '0;
		for (int i = 0; i < ENTRIES; i++) tbl_used[i] = 1'b0;
		for (int i = 0; i < plhl_pkg::NUM_LENGTHS; i++) len_count[i] = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_bucket();
		test_random(380);
		in_valid <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (error_count == 0)
			$display("prefix_length_hash_lpm verification clean");
		else
			$display("prefix_length_hash_lpm verification failed");
		$finish;
	end

endmodule
